FILE: sv/throttle_ramp_shaper_defines.svh
// Assertion macros shared by the throttle ramp shaper checker.
`ifndef THROTTLE_RAMP_SHAPER_DEFINES_SVH
`define THROTTLE_RAMP_SHAPER_DEFINES_SVH

// Both macros sample on aclk and are disabled while aresetn is low.
// The implication holds in the same cycle.
`define TRS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("throttle ramp shaper check failed");

// The consequent holds in the cycle after the antecedent.
`define TRS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("throttle ramp shaper check failed");

`endif

FILE: sv/trs_pkg.sv
// Shared types, codes and constants of the throttle ramp shaper.
package trs_pkg;

    // Command codes carried in the input tuser field.
    localparam logic [1:0] CMD_THROTTLE = 2'd0;
    localparam logic [1:0] CMD_STEER    = 2'd1;
    localparam logic [1:0] CMD_TICK     = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_LAG_GAIN    = 2'd0;
    localparam logic [1:0] CFG_DECAY_STEP  = 2'd1;
    localparam logic [1:0] CFG_STEER_LIMIT = 2'd2;
    localparam logic [1:0] CFG_SPEED_GAIN  = 2'd3;

    // Configuration reset values.
    localparam logic [15:0] LAG_GAIN_RST    = 16'd131;
    localparam logic [14:0] DECAY_STEP_RST  = 15'd27;
    localparam logic [14:0] STEER_LIMIT_RST = 15'd11469;
    localparam logic [15:0] SPEED_GAIN_RST  = 16'd1536;

    // Q2.14 constants.
    localparam logic signed [15:0] ONE_Q14   = 16'sd16384;
    localparam logic signed [15:0] HALF_Q14  = 16'sd8192;
    localparam logic        [16:0] NEAR_ZERO = 17'd819;

    // Saturation limits of a 16-bit signed result.
    localparam logic [15:0] SAT_POS = 16'h7FFF;
    localparam logic [15:0] SAT_NEG = 16'h8000;

    // Serial multiplier geometry.
    localparam int MUL_A_W   = 17;
    localparam int MUL_B_W   = 16;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = 4;
    localparam logic [MUL_CNT_W-1:0] MUL_LAST = 4'd15;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEER,
        ST_LAG,
        ST_SPEED_LOAD,
        ST_SPEED,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] mag_a;
        logic [MUL_B_W-1:0] mul_b;
    } mul_req_t;

    typedef struct packed {
        logic               done;
        logic [MUL_P_W-1:0] product;
    } mul_rsp_t;

endpackage

FILE: sv/trs_serial_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module trs_serial_mul (
    input  logic               aclk,
    input  logic               aresetn,
    input  trs_pkg::mul_req_t  req,
    output trs_pkg::mul_rsp_t  rsp
);

    logic [trs_pkg::MUL_P_W:0]     acc_reg, acc_next;
    logic [trs_pkg::MUL_A_W-1:0]   a_reg;
    logic [trs_pkg::MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [trs_pkg::MUL_A_W:0]     hi_sum;

    // The upper part accumulates the multiplicand, the lower part shifts the
    // multiplier bits out; the product is complete after the last step.
    always_comb begin
        hi_sum    = acc_reg[trs_pkg::MUL_P_W:trs_pkg::MUL_B_W]
                  + (acc_reg[0] ? {1'b0, a_reg} : '0);
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            acc_next  = {{(trs_pkg::MUL_A_W + 1){1'b0}}, req.mul_b};
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            acc_next = {1'b0, hi_sum, acc_reg[trs_pkg::MUL_B_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == trs_pkg::MUL_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (req.start) begin
            a_reg <= req.mag_a;
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg[trs_pkg::MUL_P_W-1:0];

endmodule

FILE: sv/throttle_ramp_shaper.sv
// Top level of the throttle ramp shaper: command decode, tick update and result channel.
//
// Usage. Items arrive on the s_ stream: s_tuser selects a throttle command, a
// steering command or a control tick, s_tdata carries the signed Q2.14 value.
// A throttle command is stored and the block is ready again at once. A steering
// command runs one serial multiplication. A control tick produces exactly one
// transfer on the m_ stream with the steering angle and the speed. A tick that
// decays the level runs one serial multiplication for the speed, a tick that
// follows the target through the lag runs two back to back. The rate is set by
// the single bit-serial multiplier, which retires one multiplier bit per cycle
// over 16 bits. The block takes one item at a time; s_tready is high only while
// idle. The result sits in an output register, so a new item is taken while a
// result waits; a second tick result waits in the block until the receiver takes
// the first. Configuration writes on the cfg_ channel are always ready; the user
// must make them while the block is idle, which the block does not enforce.
// Reset (aresetn low, synchronous) restores the register defaults, zero target,
// level and angle, and forward direction.
module throttle_ramp_shaper (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] command_value
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] wheel_angle, [31:16] speed
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    trs_pkg::state_t state_reg, state_next;

    logic [15:0]        lag_gain_reg, lag_gain_next;
    logic [14:0]        decay_step_reg, decay_step_next;
    logic [14:0]        steer_limit_reg, steer_limit_next;
    logic [15:0]        speed_gain_reg, speed_gain_next;

    logic signed [15:0] target_reg, target_next;
    logic signed [15:0] level_reg, level_next;
    logic               fwd_reg, fwd_next;
    logic signed [15:0] steer_reg, steer_next;
    logic               neg_reg, neg_next;
    logic [15:0]        speed_reg, speed_next;
    logic               m_valid_reg, m_valid_next;
    logic [31:0]        m_data_reg, m_data_next;

    trs_pkg::mul_req_t  mul_req;
    trs_pkg::mul_rsp_t  mul_rsp;

    logic               in_xfer;
    logic               out_free;
    logic signed [15:0] cmd_value;
    logic signed [15:0] cmd_clamp;
    logic signed [16:0] cmd_ext;
    logic [16:0]        cmd_mag;
    logic signed [16:0] level_ext;
    logic [16:0]        level_mag;
    logic               tgt_hi;
    logic               tgt_lo;
    logic               lag_keep;
    logic               near_zero;
    logic               lag_go;
    logic signed [17:0] aim;
    logic signed [17:0] diff;
    logic [16:0]        diff_mag;
    logic signed [17:0] decay_sum;
    logic signed [15:0] decay_level;
    logic [33:0]        lag_round;
    logic signed [18:0] lag_step;
    logic signed [18:0] lag_sum;
    logic signed [15:0] lag_level;

    // Round a magnitude product to nearest at bit 14, ties away from zero,
    // apply the sign and saturate to 16 bits.
    function automatic logic [15:0] round_sat14(input logic [32:0] prod, input logic neg);
        logic [33:0] rnd;
        logic [19:0] mag;
        logic [19:0] negated;
        logic [15:0] res;
        rnd     = {1'b0, prod} + 34'd8192;
        mag     = rnd[33:14];
        negated = -mag;
        if (neg) begin
            res = (mag > 20'd32768) ? trs_pkg::SAT_NEG : negated[15:0];
        end else begin
            res = (mag > 20'd32767) ? trs_pkg::SAT_POS : mag[15:0];
        end
        return res;
    endfunction

    assign in_xfer   = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // Command value clamped to plus or minus one and its magnitude.
    always_comb begin
        cmd_value = signed'(s_tdata);
        if (cmd_value > trs_pkg::ONE_Q14) begin
            cmd_clamp = trs_pkg::ONE_Q14;
        end else if (cmd_value < -trs_pkg::ONE_Q14) begin
            cmd_clamp = -trs_pkg::ONE_Q14;
        end else begin
            cmd_clamp = cmd_value;
        end
        cmd_ext = 17'(cmd_clamp);
        cmd_mag = cmd_ext[16] ? 17'(-cmd_ext) : 17'(cmd_ext);
    end

    // Tick decision: follow the target through the lag, or decay toward zero.
    always_comb begin
        level_ext = 17'(level_reg);
        level_mag = level_ext[16] ? 17'(-level_ext) : 17'(level_ext);
        tgt_hi    = target_reg > trs_pkg::HALF_Q14;
        tgt_lo    = target_reg < -trs_pkg::HALF_Q14;
        lag_keep  = (fwd_reg && tgt_hi) || (!fwd_reg && tgt_lo);
        near_zero = level_mag <= trs_pkg::NEAR_ZERO;
        lag_go    = lag_keep || (near_zero && (tgt_hi || tgt_lo));

        // The aim sits half a unit inside the target on the side of travel.
        aim      = tgt_hi ? 18'(target_reg) - 18'(trs_pkg::HALF_Q14)
                          : 18'(target_reg) + 18'(trs_pkg::HALF_Q14);
        diff     = aim - 18'(level_reg);
        diff_mag = diff[17] ? 17'(-diff) : 17'(diff);

        // Linear decay stops at zero rather than crossing it.
        if (level_reg > 16'sd0) begin
            decay_sum = 18'(level_reg) - signed'({3'b000, decay_step_reg});
            if (decay_sum[17]) begin
                decay_sum = '0;
            end
        end else begin
            decay_sum = 18'(level_reg) + signed'({3'b000, decay_step_reg});
            if (!decay_sum[17] && (decay_sum != 18'sd0)) begin
                decay_sum = '0;
            end
        end
        decay_level = decay_sum[15:0];

        // Lag step: product rounded at bit 16, signed by the difference.
        lag_round = {1'b0, mul_rsp.product} + 34'd32768;
        lag_step  = signed'({1'b0, lag_round[33:16]});
        if (neg_reg) begin
            lag_step = -lag_step;
        end
        lag_sum = 19'(level_reg) + lag_step;
        if (lag_sum > 19'sd32767) begin
            lag_level = signed'(trs_pkg::SAT_POS);
        end else if (lag_sum < -19'sd32768) begin
            lag_level = signed'(trs_pkg::SAT_NEG);
        end else begin
            lag_level = lag_sum[15:0];
        end
    end

    // Configuration register writes; values are masked to the register width.
    always_comb begin
        lag_gain_next    = lag_gain_reg;
        decay_step_next  = decay_step_reg;
        steer_limit_next = steer_limit_reg;
        speed_gain_next  = speed_gain_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                trs_pkg::CFG_LAG_GAIN:    lag_gain_next    = cfg_data;
                trs_pkg::CFG_DECAY_STEP:  decay_step_next  = cfg_data[14:0];
                trs_pkg::CFG_STEER_LIMIT: steer_limit_next = cfg_data[14:0];
                trs_pkg::CFG_SPEED_GAIN:  speed_gain_next  = cfg_data;
                default: ;
            endcase
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            trs_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    case (s_tuser)
                        trs_pkg::CMD_STEER: state_next = trs_pkg::ST_STEER;
                        trs_pkg::CMD_TICK:
                            state_next = lag_go ? trs_pkg::ST_LAG : trs_pkg::ST_SPEED_LOAD;
                        default:            state_next = trs_pkg::ST_IDLE;
                    endcase
                end
            end
            trs_pkg::ST_STEER: begin
                if (mul_rsp.done) begin
                    state_next = trs_pkg::ST_IDLE;
                end
            end
            trs_pkg::ST_LAG: begin
                if (mul_rsp.done) begin
                    state_next = trs_pkg::ST_SPEED_LOAD;
                end
            end
            trs_pkg::ST_SPEED_LOAD: state_next = trs_pkg::ST_SPEED;
            trs_pkg::ST_SPEED: begin
                if (mul_rsp.done) begin
                    state_next = trs_pkg::ST_EMIT;
                end
            end
            trs_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = trs_pkg::ST_IDLE;
                end
            end
            default: state_next = trs_pkg::ST_IDLE;
        endcase
    end

    // Outputs and datapath updates.
    always_comb begin
        s_tready      = 1'b0;
        mul_req.start = 1'b0;
        mul_req.mag_a = level_mag;
        mul_req.mul_b = speed_gain_reg;
        target_next   = target_reg;
        level_next    = level_reg;
        fwd_next      = fwd_reg;
        steer_next    = steer_reg;
        neg_next      = neg_reg;
        speed_next    = speed_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        unique case (state_reg)
            trs_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (in_xfer) begin
                    case (s_tuser)
                        trs_pkg::CMD_THROTTLE: target_next = cmd_clamp;
                        trs_pkg::CMD_STEER: begin
                            mul_req.start = 1'b1;
                            mul_req.mag_a = cmd_mag;
                            mul_req.mul_b = {1'b0, steer_limit_reg};
                            neg_next      = cmd_ext[16];
                        end
                        trs_pkg::CMD_TICK: begin
                            if (lag_go) begin
                                mul_req.start = 1'b1;
                                mul_req.mag_a = diff_mag;
                                mul_req.mul_b = lag_gain_reg;
                                neg_next      = diff[17];
                                fwd_next      = tgt_hi;
                            end else if (!near_zero) begin
                                level_next = decay_level;
                            end else begin
                                level_next = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            trs_pkg::ST_STEER: begin
                if (mul_rsp.done) begin
                    steer_next = signed'(round_sat14(mul_rsp.product, neg_reg));
                end
            end
            trs_pkg::ST_LAG: begin
                if (mul_rsp.done) begin
                    level_next = lag_level;
                end
            end
            trs_pkg::ST_SPEED_LOAD: begin
                mul_req.start = 1'b1;
                mul_req.mag_a = level_mag;
                mul_req.mul_b = speed_gain_reg;
                neg_next      = level_reg[15];
            end
            trs_pkg::ST_SPEED: begin
                if (mul_rsp.done) begin
                    speed_next = round_sat14(mul_rsp.product, neg_reg);
                end
            end
            trs_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {speed_reg, steer_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= trs_pkg::ST_IDLE;
            lag_gain_reg    <= trs_pkg::LAG_GAIN_RST;
            decay_step_reg  <= trs_pkg::DECAY_STEP_RST;
            steer_limit_reg <= trs_pkg::STEER_LIMIT_RST;
            speed_gain_reg  <= trs_pkg::SPEED_GAIN_RST;
            target_reg      <= '0;
            level_reg       <= '0;
            fwd_reg         <= 1'b1;
            steer_reg       <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            lag_gain_reg    <= lag_gain_next;
            decay_step_reg  <= decay_step_next;
            steer_limit_reg <= steer_limit_next;
            speed_gain_reg  <= speed_gain_next;
            target_reg      <= target_next;
            level_reg       <= level_next;
            fwd_reg         <= fwd_next;
            steer_reg       <= steer_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        neg_reg    <= neg_next;
        speed_reg  <= speed_next;
        m_data_reg <= m_data_next;
    end

    trs_serial_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

FILE: sv/trs_checker.sv
// Port-level checker of the throttle ramp shaper and its bind statement.
`include "throttle_ramp_shaper_defines.svh"

module trs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    logic tick_xfer;
    logic steer_xfer;
    logic throttle_xfer;

    assign tick_xfer     = s_tvalid && s_tready && (s_tuser == trs_pkg::CMD_TICK);
    assign steer_xfer    = s_tvalid && s_tready && (s_tuser == trs_pkg::CMD_STEER);
    assign throttle_xfer = s_tvalid && s_tready && (s_tuser == trs_pkg::CMD_THROTTLE);

    // A stalled result holds.
    `TRS_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // A tick and a steering command each keep the block busy for a while.
    `TRS_ASSERT_NXT(a_tick_busy, tick_xfer, !s_tready)
    `TRS_ASSERT_NXT(a_steer_busy, steer_xfer, !s_tready)
    // A throttle command is stored at once.
    `TRS_ASSERT_NXT(a_throttle_ready, throttle_xfer, s_tready)
    // The steering angle is bounded by the 15-bit limit.
    `TRS_ASSERT_IMP(a_angle_range, m_tvalid, m_tdata[15:0] != 16'h8000)

endmodule

bind throttle_ramp_shaper trs_checker u_trs_checker (.*);

FILE: tb/testbench.sv
// Self-checking testbench of the throttle ramp shaper with a tick-result predictor.
module testbench;

    // Cycles without any transfer on any channel before the run is abandoned.
    // The slowest item is a lag tick, which runs two serial multiplications, so
    // this leaves a wide margin over it and over the stalls and gaps.
    localparam int IDLE_LIMIT    = 2000;
    // Longest item latency plus margin: the pause before a register write and
    // the drain at the end of the run.
    localparam int SETTLE_CYCLES = 40;

    localparam int ONE_I  = trs_pkg::ONE_Q14;
    localparam int HALF_I = trs_pkg::HALF_Q14;
    localparam int NEAR_I = trs_pkg::NEAR_ZERO;

    // The command code that has no meaning and must be ignored.
    localparam logic [1:0] CMD_SPARE = 2'd3;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [15:0] command_value
    logic [1:0]  s_tuser;   // [1:0] cmd
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [15:0] wheel_angle, [31:16] speed
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // When set, neither the sender nor the receiver inserts idle cycles.
    logic        calm = 1'b0;
    int          idle_cycles = 0;

    // One tick result as it appears on m_tdata.
    typedef struct packed {
        logic signed [15:0] speed;
        logic signed [15:0] angle;
    } drive_t;

    // Tracks the shaper state and configuration, and holds the tick results
    // that are still due on the output stream.
    class drive_predictor;
        logic [15:0]        lag_gain;
        logic [14:0]        decay_step;
        logic [14:0]        steer_limit;
        logic [15:0]        speed_gain;
        logic signed [15:0] target;
        logic signed [15:0] level;
        logic signed [15:0] angle;
        logic               forward;
        drive_t             due[$];
        int                 errors;

        function new();
            lag_gain    = trs_pkg::LAG_GAIN_RST;
            decay_step  = trs_pkg::DECAY_STEP_RST;
            steer_limit = trs_pkg::STEER_LIMIT_RST;
            speed_gain  = trs_pkg::SPEED_GAIN_RST;
            target      = '0;
            level       = '0;
            angle       = '0;
            forward     = 1'b1;
            errors      = 0;
        endfunction

        function logic signed [15:0] sat16(longint v);
            if (v > 32767) return trs_pkg::SAT_POS;
            if (v < -32768) return trs_pkg::SAT_NEG;
            return v[15:0];
        endfunction

        // Rounds to nearest with ties away from zero, then drops s bits.
        function longint round_shift(longint p, int s);
            longint m;
            m = (p < 0) ? -p : p;
            m = (m + (longint'(1) << (s - 1))) >> s;
            return (p < 0) ? -m : m;
        endfunction

        function int clamp_one(logic signed [15:0] v);
            int x;
            x = v;
            if (x > ONE_I) return ONE_I;
            if (x < -ONE_I) return -ONE_I;
            return x;
        endfunction

        function void lag_toward(int aim);
            longint diff;
            diff  = longint'(aim) - longint'(level);
            level = sat16(longint'(level) + round_shift(longint'(lag_gain) * diff, 16));
        endfunction

        function void update_level();
            int t;
            int l;
            int mag;
            int nxt;
            t = target;
            l = level;
            if (forward && t > HALF_I) begin
                lag_toward(t - HALF_I);
            end else if (!forward && t < -HALF_I) begin
                lag_toward(t + HALF_I);
            end else begin
                mag = (l < 0) ? -l : l;
                if (mag > NEAR_I) begin
                    // Linear decay that stops at zero instead of crossing it.
                    if (l > 0) begin
                        nxt = l - int'(decay_step);
                        if (nxt < 0) nxt = 0;
                    end else begin
                        nxt = l + int'(decay_step);
                        if (nxt > 0) nxt = 0;
                    end
                    level = sat16(nxt);
                end else if (t > HALF_I) begin
                    forward = 1'b1;
                    lag_toward(t - HALF_I);
                end else if (t < -HALF_I) begin
                    forward = 1'b0;
                    lag_toward(t + HALF_I);
                end else begin
                    level = '0;
                end
            end
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] d);
            case (idx)
                trs_pkg::CFG_LAG_GAIN:    lag_gain    = d;
                trs_pkg::CFG_DECAY_STEP:  decay_step  = d[14:0];
                trs_pkg::CFG_STEER_LIMIT: steer_limit = d[14:0];
                trs_pkg::CFG_SPEED_GAIN:  speed_gain  = d;
                default: ;
            endcase
        endfunction

        // Applies one accepted input item; a tick queues its result.
        function void take_item(logic [1:0] cmd, logic [15:0] v);
            drive_t res;
            case (cmd)
                trs_pkg::CMD_THROTTLE: target = 16'(clamp_one(v));
                trs_pkg::CMD_STEER: angle = sat16(round_shift(
                    longint'(clamp_one(v)) * longint'(steer_limit), 14));
                trs_pkg::CMD_TICK: begin
                    update_level();
                    res.angle = angle;
                    res.speed = sat16(round_shift(
                        longint'(speed_gain) * longint'(level), 14));
                    due.push_back(res);
                end
                default: ;
            endcase
        endfunction

        function void check_drive(logic [31:0] d);
            drive_t got;
            drive_t want;
            got = d;
            if (due.size() == 0) begin
                $display("%0t: unexpected result, angle %0d speed %0d",
                         $time, got.angle, got.speed);
                errors++;
                return;
            end
            want = due.pop_front();
            if (got.angle !== want.angle) begin
                $display("%0t: wheel_angle expected %0d, got %0d",
                         $time, want.angle, got.angle);
                errors++;
            end
            if (got.speed !== want.speed) begin
                $display("%0t: speed expected %0d, got %0d",
                         $time, want.speed, got.speed);
                errors++;
            end
        endfunction

        function int pending();
            return due.size();
        endfunction
    endclass

    drive_predictor predictor;

    throttle_ramp_shaper u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Idle stretch length: mostly none or short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    // Presents one item after a gap and returns at the edge where the
    // transfer happens. The valid stays high so that a back-to-back item
    // only changes the payload at the next falling edge.
    task automatic send_item(logic [1:0] cmd, logic [15:0] val);
        int gap;
        gap = idle_len();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= val;
        do @(posedge aclk); while (!s_tready);
        predictor.take_item(cmd, val);
    endtask

    // Stops the input stream and waits until every tick result has arrived
    // and the block has had time to finish a command that gives no result.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (predictor.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Writes all four registers in one burst with the valid held high.
    task automatic write_config(logic [15:0] lag, logic [15:0] decay,
                                logic [15:0] steer, logic [15:0] gain);
        logic [15:0] vals [4];
        logic [1:0]  idxs [4];
        vals = '{lag, decay, steer, gain};
        idxs = '{trs_pkg::CFG_LAG_GAIN, trs_pkg::CFG_DECAY_STEP,
                 trs_pkg::CFG_STEER_LIMIT, trs_pkg::CFG_SPEED_GAIN};
        for (int i = 0; i < 4; i++) begin
            @(negedge aclk);
            cfg_valid <= 1'b1;
            cfg_index <= idxs[i];
            cfg_data  <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
            predictor.write_reg(idxs[i], vals[i]);
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Command values lean toward the range that matters, with the clamp
    // limits, the deadband edges and raw 16-bit values mixed in.
    function automatic logic [15:0] command_value();
        logic [15:0] edges [10];
        int r;
        edges = '{16'h7FFF, 16'h8000, 16'd16384, -16'sd16384, 16'd8192,
                  -16'sd8192, 16'd8193, -16'sd8193, 16'd0, 16'd820};
        r = $urandom_range(0, 9);
        if (r == 0) return edges[$urandom_range(0, 9)];
        if (r == 1) return 16'($urandom);
        return 16'($urandom_range(0, 32768) - 16384);
    endfunction

    // Short fixed sequence at reset settings: clamping at both ends, the
    // ignored command code, the lag in both directions with a direction flip
    // near zero, and the deadband edge that forces the level to zero.
    task automatic run_directed();
        send_item(trs_pkg::CMD_TICK, 16'hFFFF);
        send_item(trs_pkg::CMD_STEER, 16'h7FFF);
        send_item(trs_pkg::CMD_TICK, 16'h0000);
        send_item(trs_pkg::CMD_STEER, 16'h8000);
        send_item(trs_pkg::CMD_THROTTLE, 16'h7FFF);
        repeat (3) send_item(trs_pkg::CMD_TICK, 16'h5555);
        send_item(CMD_SPARE, 16'h8000);
        send_item(CMD_SPARE, 16'h7FFF);
        send_item(trs_pkg::CMD_TICK, 16'hAAAA);
        send_item(trs_pkg::CMD_THROTTLE, 16'h8000);
        repeat (3) send_item(trs_pkg::CMD_TICK, 16'h0000);
        send_item(trs_pkg::CMD_THROTTLE, 16'd8192);
        repeat (2) send_item(trs_pkg::CMD_TICK, 16'h0000);
        send_item(trs_pkg::CMD_THROTTLE, -16'sd8193);
        send_item(trs_pkg::CMD_STEER, 16'd0);
        send_item(trs_pkg::CMD_TICK, 16'h0000);
        send_item(trs_pkg::CMD_THROTTLE, 16'd0);
        send_item(trs_pkg::CMD_TICK, 16'h0000);
    endtask

    // Random part: mostly episodes of a throttle command, maybe a steering
    // command, and a run of ticks; the rest is loose items of any code.
    task automatic run_random(int budget);
        int count;
        int ticks;
        logic [1:0] cmd;
        count = 0;
        while (count < budget) begin
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) < 8) begin
                send_item(trs_pkg::CMD_THROTTLE, command_value());
                count++;
                if ($urandom_range(0, 2) == 0) begin
                    send_item(trs_pkg::CMD_STEER, command_value());
                    count++;
                end
                ticks = $urandom_range(2, 40);
                repeat (ticks) send_item(trs_pkg::CMD_TICK, 16'($urandom));
                count += ticks;
            end else begin
                cmd = 2'($urandom_range(0, 3));
                send_item(cmd, 16'($urandom));
                if (cmd != CMD_SPARE) count++;
            end
        end
        calm = 1'b0;
    endtask

    // Receiver: ready for a few cycles, then a random stall.
    initial begin
        int hold;
        int stall;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready <= 1'b1;
            hold = $urandom_range(0, 7);
            repeat (hold) @(negedge aclk);
            stall = idle_len();
            if (stall > 0) begin
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
        end
    end

    // Every result transfer is checked against the oldest due result.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) predictor.check_drive(m_tdata);
    end

    // Watchdog on cycles with no transfer on any channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("testbench failed");
            $finish;
        end
    end

    initial begin
        predictor = new();
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings first.
        run_directed();
        drain();

        // Upper extremes: fastest lag, a decay step of one full unit, full steering range and
        // a speed gain that drives the speed into saturation.
        write_config(16'hFFFF, 16'd16384, 16'h7FFF, 16'hFFFF);
        run_random(180);
        drain();

        // Lower extremes; bit 15 on the 15-bit registers is dropped, so
        // decay and steering limit end up at zero.
        write_config(16'h0000, 16'h8000, 16'h8000, 16'h0000);
        run_random(100);
        drain();

        // Mid-range settings where the lag, decay and direction flips mix.
        repeat (4) begin
            write_config(16'($urandom_range(500, 40000)), 16'($urandom_range(8, 3000)),
                         16'($urandom), 16'($urandom));
            run_random(200);
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (predictor.errors == 0 && predictor.pending() == 0) begin
            $display("testbench passed");
        end else begin
            if (predictor.pending() != 0)
                $display("%0t: %0d results never arrived", $time, predictor.pending());
            $display("testbench failed");
        end
        $finish;
    end

endmodule

FILE: throttle_ramp_shaper.f
+incdir+sv
sv/trs_pkg.sv
sv/trs_serial_mul.sv
sv/throttle_ramp_shaper.sv
sv/trs_checker.sv
tb/testbench.sv
